FILE: sv/pdl_pkg.sv
// ----------------------------------------------------------------------------
// pdl_pkg
// Shared widths, command, status and operation codes for the linked list unit.
// ----------------------------------------------------------------------------
package pdl_pkg;

	localparam int DEPTH_DEF      = 16;
	localparam int DATA_WIDTH_DEF = 32;

	localparam int CMD_W  = 3;
	localparam int POS_W  = 5;
	localparam int WORD_W = 32;
	localparam int STAT_W = 2;
	localparam int LEN_W  = 5;

	typedef logic [CMD_W-1:0]  cmd_t;
	typedef logic [STAT_W-1:0] stat_t;
	typedef logic [2:0]        kind_t;

	localparam cmd_t CMD_PUSH_FRONT = 3'd0;
	localparam cmd_t CMD_PUSH_BACK  = 3'd1;
	localparam cmd_t CMD_INSERT     = 3'd2;
	localparam cmd_t CMD_POP_FRONT  = 3'd3;
	localparam cmd_t CMD_POP_BACK   = 3'd4;
	localparam cmd_t CMD_REMOVE     = 3'd5;

	localparam stat_t ST_OK    = 2'd0;
	localparam stat_t ST_EMPTY = 2'd1;
	localparam stat_t ST_FULL  = 2'd2;
	localparam stat_t ST_RANGE = 2'd3;

	// internal operation after decode
	localparam kind_t K_FRONT = 3'd0;
	localparam kind_t K_BACK  = 3'd1;
	localparam kind_t K_IMID  = 3'd2;
	localparam kind_t K_HEAD  = 3'd3;
	localparam kind_t K_TAIL  = 3'd4;
	localparam kind_t K_RMID  = 3'd5;

endpackage

FILE: sv/pdl_ram.sv
// ----------------------------------------------------------------------------
// pdl_ram
// Simple dual port RAM, one write and one read per cycle, registered read data.
// ----------------------------------------------------------------------------
module pdl_ram #(
	parameter int W = pdl_pkg::WORD_W,
	parameter int D = pdl_pkg::DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);

	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

FILE: sv/positional_deque_list_unit.sv
// ----------------------------------------------------------------------------
// positional_deque_list_unit
// Bounded doubly linked list in RAM: push/pop at both ends, insert/remove at
// a position, one result word per command.
// ----------------------------------------------------------------------------
//  channel | signals                          | handshake
//  --------+----------------------------------+-------------------
//  in      | command, position, data_in       | in_valid / in_stall
//  out     | data_out, status, length         | out_valid / out_stall
//
// One command at a time. Pushes and pops work at the ends without a walk;
// insert and remove at an inner position first walk the next-link RAM from
// the head, one link per cycle. Rejected and unused commands post their result
// without touching the RAMs. The next command can be accepted in the cycle
// after the result is posted; a result held by out_stall delays the next.
// No clearing pass after reset: slots never handed out read their free link
// as index + 1, the last slot wrapping to 0.
// ----------------------------------------------------------------------------
module positional_deque_list_unit #(
	parameter int DEPTH      = pdl_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = pdl_pkg::DATA_WIDTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [pdl_pkg::CMD_W-1:0]  command,
	input  logic [pdl_pkg::POS_W-1:0]  position,
	input  logic [pdl_pkg::WORD_W-1:0] data_in,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [pdl_pkg::WORD_W-1:0] data_out,
	output logic [pdl_pkg::STAT_W-1:0] status,
	output logic [pdl_pkg::LEN_W-1:0]  length
);

	localparam int IW   = $clog2(DEPTH);
	localparam int CW   = $clog2(DEPTH + 1);
	localparam int CMPW = (CW > pdl_pkg::POS_W) ? CW + 1 : pdl_pkg::POS_W + 1;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_FREE   = 4'd1;
	localparam logic [3:0] S_FREE_W = 4'd2;
	localparam logic [3:0] S_WSTART = 4'd3;
	localparam logic [3:0] S_WALK   = 4'd4;
	localparam logic [3:0] S_WEND   = 4'd5;
	localparam logic [3:0] S_B      = 4'd6;
	localparam logic [3:0] S_RH     = 4'd7;
	localparam logic [3:0] S_RH_W   = 4'd8;
	localparam logic [3:0] S_RT     = 4'd9;
	localparam logic [3:0] S_RT_W   = 4'd10;
	localparam logic [3:0] S_W1     = 4'd11;
	localparam logic [3:0] S_W2     = 4'd12;
	localparam logic [3:0] S_DONE   = 4'd13;

	logic [3:0]            state_q;
	pdl_pkg::kind_t        kind_q;
	logic [IW-1:0]         head_q, tail_q, free_q;
	logic [CW-1:0]         cnt_q, fresh_q, r_q;
	logic [IW-1:0]         cur_q, a_q, at_q, b_q, s_q;
	logic [pdl_pkg::WORD_W-1:0] data_q;
	logic [DATA_WIDTH-1:0] removed_q;
	pdl_pkg::stat_t        res_stat_q;
	logic                  res_word_q;

	// memory ports
	logic                  nxt_we, prv_we, wrd_we;
	logic [IW-1:0]         nxt_wa, prv_wa, wrd_wa;
	logic [IW-1:0]         nxt_wd, prv_wd;
	logic [DATA_WIDTH-1:0] wrd_wd;
	logic [IW-1:0]         nxt_ra, prv_ra, wrd_ra;
	logic [IW-1:0]         nxt_rd, prv_rd;
	logic [DATA_WIDTH-1:0] wrd_rd;

	pdl_ram #(.W(IW), .D(DEPTH)) u_next (
		.clk(clk), .we(nxt_we), .waddr(nxt_wa), .wdata(nxt_wd),
		.raddr(nxt_ra), .rdata(nxt_rd)
	);
	pdl_ram #(.W(IW), .D(DEPTH)) u_prev (
		.clk(clk), .we(prv_we), .waddr(prv_wa), .wdata(prv_wd),
		.raddr(prv_ra), .rdata(prv_rd)
	);
	pdl_ram #(.W(DATA_WIDTH), .D(DEPTH)) u_word (
		.clk(clk), .we(wrd_we), .waddr(wrd_wa), .wdata(wrd_wd),
		.raddr(wrd_ra), .rdata(wrd_rd)
	);

	logic            accept;
	logic [CMPW-1:0] p_x, c_x;
	logic            cnt_nz;
	logic [63:0]     din_wide, rem_wide;
	logic [IW-1:0]   free_inc, fnext;
	logic            free_fresh;

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign p_x      = CMPW'(position);
	assign c_x      = CMPW'(cnt_q);
	assign cnt_nz   = (cnt_q != '0);
	assign din_wide = 64'(data_q);
	assign rem_wide = 64'(removed_q);

	// untouched slots chain to index + 1, the last slot wrapping to 0
	assign free_inc   = (free_q == IW'(DEPTH - 1)) ? '0 : free_q + 1'b1;
	assign free_fresh = (CW'(free_q) >= fresh_q);
	assign fnext      = free_fresh ? free_inc : nxt_rd;

	always_comb begin
		unique case (state_q)
			S_FREE:   nxt_ra = free_q;
			S_WSTART: nxt_ra = cur_q;
			S_WALK:   nxt_ra = nxt_rd;
			S_WEND:   nxt_ra = nxt_rd;
			S_RH:     nxt_ra = head_q;
			default:  nxt_ra = cur_q;
		endcase
		unique case (state_q)
			S_WEND:  wrd_ra = nxt_rd;
			S_RT:    wrd_ra = tail_q;
			default: wrd_ra = head_q;
		endcase
		prv_ra = tail_q;
	end

	always_comb begin
		nxt_we = 1'b0; nxt_wa = s_q; nxt_wd = '0;
		prv_we = 1'b0; prv_wa = s_q; prv_wd = '0;
		wrd_we = 1'b0; wrd_wa = s_q; wrd_wd = din_wide[DATA_WIDTH-1:0];
		if (state_q == S_W1) begin
			unique case (kind_q)
				pdl_pkg::K_FRONT: begin
					wrd_we = 1'b1;
					nxt_we = 1'b1; nxt_wd = cnt_nz ? head_q : '0;
					prv_we = 1'b1;
				end
				pdl_pkg::K_BACK: begin
					wrd_we = 1'b1;
					nxt_we = 1'b1;
					prv_we = 1'b1; prv_wd = cnt_nz ? tail_q : '0;
				end
				pdl_pkg::K_IMID: begin
					wrd_we = 1'b1;
					nxt_we = 1'b1; nxt_wd = at_q;
					prv_we = 1'b1; prv_wd = a_q;
				end
				pdl_pkg::K_HEAD: begin
					prv_we = (cnt_q != CW'(1)); prv_wa = b_q;
				end
				pdl_pkg::K_TAIL: begin
					nxt_we = (cnt_q != CW'(1)); nxt_wa = a_q;
				end
				pdl_pkg::K_RMID: begin
					nxt_we = 1'b1; nxt_wa = a_q; nxt_wd = b_q;
					prv_we = 1'b1; prv_wa = b_q; prv_wd = a_q;
				end
				default: ;
			endcase
		end else if (state_q == S_W2) begin
			unique case (kind_q)
				pdl_pkg::K_FRONT: begin
					prv_we = cnt_nz; prv_wa = head_q; prv_wd = s_q;
				end
				pdl_pkg::K_BACK: begin
					nxt_we = cnt_nz; nxt_wa = tail_q; nxt_wd = s_q;
				end
				pdl_pkg::K_IMID: begin
					nxt_we = 1'b1; nxt_wa = a_q;  nxt_wd = s_q;
					prv_we = 1'b1; prv_wa = at_q; prv_wd = s_q;
				end
				default: begin
					// removed slot goes on the front of the free chain
					nxt_we = 1'b1; nxt_wa = s_q; nxt_wd = free_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			kind_q     <= pdl_pkg::K_FRONT;
			head_q     <= '0;
			tail_q     <= '0;
			free_q     <= '0;
			cnt_q      <= '0;
			fresh_q    <= '0;
			r_q        <= '0;
			res_stat_q <= pdl_pkg::ST_OK;
			res_word_q <= 1'b0;
			out_valid  <= 1'b0;
		end else begin
			if (out_valid && !out_stall && state_q != S_DONE) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						res_stat_q <= pdl_pkg::ST_OK;
						res_word_q <= 1'b0;
						cur_q      <= head_q;
						r_q        <= CW'(p_x - 1'b1);
						data_q     <= data_in;
						if (command <= pdl_pkg::CMD_INSERT) begin
							if (c_x >= CMPW'(DEPTH)) begin
								res_stat_q <= pdl_pkg::ST_FULL;
								state_q    <= S_DONE;
							end else if (command == pdl_pkg::CMD_PUSH_FRONT ||
									p_x == '0 && command == pdl_pkg::CMD_INSERT) begin
								kind_q  <= pdl_pkg::K_FRONT;
								state_q <= S_FREE;
							end else if (command == pdl_pkg::CMD_PUSH_BACK || p_x == c_x) begin
								kind_q  <= pdl_pkg::K_BACK;
								state_q <= S_FREE;
							end else if (p_x > c_x) begin
								res_stat_q <= pdl_pkg::ST_RANGE;
								state_q    <= S_DONE;
							end else begin
								kind_q  <= pdl_pkg::K_IMID;
								state_q <= S_FREE;
							end
						end else if (command <= pdl_pkg::CMD_REMOVE) begin
							if (!cnt_nz) begin
								res_stat_q <= pdl_pkg::ST_EMPTY;
								state_q    <= S_DONE;
							end else if (command == pdl_pkg::CMD_POP_FRONT ||
									(command == pdl_pkg::CMD_REMOVE && p_x == '0 &&
									 c_x != '0)) begin
								kind_q  <= pdl_pkg::K_HEAD;
								state_q <= S_RH;
							end else if (command == pdl_pkg::CMD_POP_BACK) begin
								kind_q  <= pdl_pkg::K_TAIL;
								state_q <= S_RT;
							end else if (p_x >= c_x) begin
								res_stat_q <= pdl_pkg::ST_RANGE;
								state_q    <= S_DONE;
							end else if (p_x == c_x - 1'b1) begin
								kind_q  <= pdl_pkg::K_TAIL;
								state_q <= S_RT;
							end else begin
								kind_q  <= pdl_pkg::K_RMID;
								state_q <= S_WSTART;
							end
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_FREE: state_q <= S_FREE_W;
				S_FREE_W: begin
					s_q    <= free_q;
					free_q <= fnext;
					if (free_fresh && fresh_q < CW'(DEPTH)) begin
						fresh_q <= fresh_q + 1'b1;
					end
					state_q <= (kind_q == pdl_pkg::K_IMID) ? S_WSTART : S_W1;
				end
				S_WSTART: state_q <= (r_q == '0) ? S_WEND : S_WALK;
				S_WALK: begin
					cur_q <= nxt_rd;
					r_q   <= r_q - 1'b1;
					if (r_q == CW'(1)) begin
						state_q <= S_WEND;
					end
				end
				S_WEND: begin
					a_q     <= cur_q;
					at_q    <= nxt_rd;
					state_q <= (kind_q == pdl_pkg::K_RMID) ? S_B : S_W1;
				end
				S_B: begin
					b_q        <= nxt_rd;
					s_q        <= at_q;
					removed_q  <= wrd_rd;
					res_word_q <= 1'b1;
					state_q    <= S_W1;
				end
				S_RH: state_q <= S_RH_W;
				S_RH_W: begin
					b_q        <= nxt_rd;
					s_q        <= head_q;
					removed_q  <= wrd_rd;
					res_word_q <= 1'b1;
					state_q    <= S_W1;
				end
				S_RT: state_q <= S_RT_W;
				S_RT_W: begin
					a_q        <= prv_rd;
					s_q        <= tail_q;
					removed_q  <= wrd_rd;
					res_word_q <= 1'b1;
					state_q    <= S_W1;
				end
				S_W1: state_q <= S_W2;
				S_W2: begin
					state_q <= S_DONE;
					if (kind_q <= pdl_pkg::K_IMID) begin
						cnt_q <= cnt_q + 1'b1;
						if (kind_q == pdl_pkg::K_FRONT) begin
							head_q <= s_q;
							if (!cnt_nz) tail_q <= s_q;
						end else if (kind_q == pdl_pkg::K_BACK) begin
							tail_q <= s_q;
							if (!cnt_nz) head_q <= s_q;
						end
					end else begin
						cnt_q  <= cnt_q - 1'b1;
						free_q <= s_q;
						if (cnt_q == CW'(1)) begin
							head_q <= '0;
							tail_q <= '0;
						end else if (kind_q == pdl_pkg::K_HEAD) begin
							head_q <= b_q;
						end else if (kind_q == pdl_pkg::K_TAIL) begin
							tail_q <= a_q;
						end
					end
				end
				S_DONE: begin
					if (!out_valid || !out_stall) begin
						out_valid <= 1'b1;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result word register
	always_ff @(posedge clk) begin
		if (state_q == S_DONE && (!out_valid || !out_stall)) begin
			data_out <= res_word_q ? rem_wide[pdl_pkg::WORD_W-1:0] : '0;
			status   <= res_stat_q;
			length   <= pdl_pkg::LEN_W'(cnt_q);
		end
	end

endmodule

FILE: test/tb_positional_deque_list_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_positional_deque_list_unit
// Drives list commands (pushes, pops, positional insert and remove, unused
// codes) with random idling on both sides. A queue model of the list predicts
// the removed word, status and length of every command; results are checked
// in order against the predictions.
// ----------------------------------------------------------------------------
module tb_positional_deque_list_unit;

	localparam int DEPTH = pdl_pkg::DEPTH_DEF;

	logic                       clk;
	logic                       arst_n;
	logic                       in_valid;
	logic                       in_stall;
	logic [pdl_pkg::CMD_W-1:0]  command;
	logic [pdl_pkg::POS_W-1:0]  position;
	logic [pdl_pkg::WORD_W-1:0] data_in;
	logic                       out_valid;
	logic                       out_stall;
	logic [pdl_pkg::WORD_W-1:0] data_out;
	logic [pdl_pkg::STAT_W-1:0] status;
	logic [pdl_pkg::LEN_W-1:0]  length;

	typedef struct packed {
		logic [pdl_pkg::WORD_W-1:0] word;
		logic [pdl_pkg::STAT_W-1:0] stat;
		logic [pdl_pkg::LEN_W-1:0]  len;
	} outcome_t;

	logic [pdl_pkg::WORD_W-1:0] list_words[$];
	outcome_t                   pending_outcomes[$];
	int                         error_count;
	bit                         quiet;

	positional_deque_list_unit #(.DEPTH(DEPTH), .DATA_WIDTH(pdl_pkg::DATA_WIDTH_DEF)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.command(command), .position(position), .data_in(data_in),
		.out_valid(out_valid), .out_stall(out_stall),
		.data_out(data_out), .status(status), .length(length)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("%0t: %s got %0h expected %0h", $realtime, what, got, want);
		error_count++;
	endtask

	function automatic outcome_t list_apply(input pdl_pkg::cmd_t cmd, input int pos,
			input logic [31:0] w);
		outcome_t r;
		int n;
		n = list_words.size();
		r = '0;
		case (cmd)
			pdl_pkg::CMD_PUSH_FRONT, pdl_pkg::CMD_PUSH_BACK, pdl_pkg::CMD_INSERT: begin
				if (n >= DEPTH) r.stat = pdl_pkg::ST_FULL;
				else if (cmd == pdl_pkg::CMD_PUSH_FRONT) list_words.push_front(w);
				else if (cmd == pdl_pkg::CMD_PUSH_BACK) list_words.push_back(w);
				else if (pos > n) r.stat = pdl_pkg::ST_RANGE;
				else list_words.insert(pos, w);
			end
			pdl_pkg::CMD_POP_FRONT, pdl_pkg::CMD_POP_BACK, pdl_pkg::CMD_REMOVE: begin
				if (n == 0) r.stat = pdl_pkg::ST_EMPTY;
				else if (cmd == pdl_pkg::CMD_POP_FRONT) r.word = list_words.pop_front();
				else if (cmd == pdl_pkg::CMD_POP_BACK) r.word = list_words.pop_back();
				else if (pos >= n) r.stat = pdl_pkg::ST_RANGE;
				else begin
					r.word = list_words[pos];
					list_words.delete(pos);
				end
			end
			default: ;
		endcase
		r.len = pdl_pkg::LEN_W'(list_words.size());
		return r;
	endfunction

	// idle bursts on the sender side, then hold the word until accepted
	task automatic send_word(input pdl_pkg::cmd_t cmd, input logic [4:0] pos,
			input logic [31:0] w);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid <= 1'b1;
		command  <= cmd;
		position <= pos;
		data_in  <= w;
		pending_outcomes.push_back(list_apply(cmd, int'(pos), w));
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_outcomes.size() != 0) @(posedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_outcomes.size() == 0) report("unexpected word", data_out, '0);
			else begin
				outcome_t e;
				e = pending_outcomes.pop_front();
				if (data_out !== e.word) report("data_out", data_out, e.word);
				if (status !== e.stat) report("status", 32'(status), 32'(e.stat));
				if (length !== e.len) report("length", 32'(length), 32'(e.len));
			end
		end
	end

	// receiver stall bursts
	initial begin
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (!quiet && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 6)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	task automatic test_directed;
		send_word(pdl_pkg::CMD_POP_FRONT, 0, 0);
		send_word(pdl_pkg::CMD_POP_BACK, 0, 0);
		send_word(pdl_pkg::CMD_REMOVE, 31, 0);
		send_word(pdl_pkg::CMD_INSERT, 1, 32'h1);
		send_word(pdl_pkg::CMD_INSERT, 0, 32'hFFFFFFFF);
		send_word(pdl_pkg::CMD_INSERT, 1, 32'h0);
		send_word(pdl_pkg::CMD_PUSH_FRONT, 0, 32'hAAAA5555);
		send_word(pdl_pkg::CMD_PUSH_BACK, 0, 32'h5555AAAA);
		send_word(pdl_pkg::CMD_INSERT, 2, 32'h12345678);
		send_word(3'd6, 5, 32'hDEAD);
		send_word(3'd7, 0, 32'hBEEF);
		send_word(pdl_pkg::CMD_REMOVE, 5, 0);
		send_word(pdl_pkg::CMD_REMOVE, 2, 0);
		send_word(pdl_pkg::CMD_REMOVE, 0, 0);
		send_word(pdl_pkg::CMD_POP_BACK, 0, 0);
		send_word(pdl_pkg::CMD_POP_FRONT, 0, 0);
		send_word(pdl_pkg::CMD_POP_FRONT, 0, 0);
		drain();
	endtask

	task automatic test_fill_and_full;
		for (int i = 0; i < DEPTH; i++)
			send_word(pdl_pkg::CMD_INSERT, 5'(list_words.size()), $urandom);
		send_word(pdl_pkg::CMD_PUSH_FRONT, 0, 1);
		send_word(pdl_pkg::CMD_INSERT, 16, 2);
		send_word(pdl_pkg::CMD_REMOVE, 16, 0);
		send_word(pdl_pkg::CMD_REMOVE, 15, 0);
		send_word(pdl_pkg::CMD_INSERT, 15, 3);
		drain();
	endtask

	task automatic test_random(input int count);
		int n;
		pdl_pkg::cmd_t c;
		logic [4:0] p;
		for (int i = 0; i < count; i++) begin
			n = list_words.size();
			if ($urandom_range(0, 19) == 0) c = pdl_pkg::cmd_t'($urandom_range(6, 7));
			else if (n < 4 && $urandom_range(0, 1)) c = pdl_pkg::cmd_t'($urandom_range(0, 2));
			else if (n > 12 && $urandom_range(0, 1)) c = pdl_pkg::cmd_t'($urandom_range(3, 5));
			else c = pdl_pkg::cmd_t'($urandom_range(0, 5));
			if ($urandom_range(0, 9) == 0) p = 5'($urandom);
			else p = 5'($urandom_range(0, n));
			send_word(c, p, $urandom);
		end
		drain();
	endtask

	initial begin
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		command     = '0;
		position    = '0;
		data_in     = '0;
		error_count = 0;
		quiet       = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_fill_and_full();
		test_random(850);
		quiet = 1'b1;
		test_random(150);
		repeat (40) @(posedge clk);
		if (error_count == 0) $display("SCOREBOARD CLEAN");
		else $display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

FILE: files.f
sv/pdl_pkg.sv
sv/pdl_ram.sv
sv/positional_deque_list_unit.sv
test/tb_positional_deque_list_unit.sv
